// ----- design/ctok_pkg.sv -----
// shared types and constants of the c subset tokenizer
package ctok_pkg;

  // token kinds
  localparam logic [2:0] KIND_RES = 3'd0;
  localparam logic [2:0] KIND_NUM = 3'd1;
  localparam logic [2:0] KIND_ID  = 3'd2;
  localparam logic [2:0] KIND_EOF = 3'd3;
  localparam logic [2:0] KIND_ERR = 3'd4;

  // reserved codes used by name
  localparam logic [4:0] CODE_NONE  = 5'd0;
  localparam logic [4:0] CODE_EQEQ  = 5'd6;
  localparam logic [4:0] CODE_NE    = 5'd7;
  localparam logic [4:0] CODE_LE    = 5'd8;
  localparam logic [4:0] CODE_GE    = 5'd9;
  localparam logic [4:0] CODE_PUNCT = 5'd10;

  localparam logic [30:0] VAL_MAX = 31'h7FFF_FFFF;
  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  // keywords, packed big-endian into the low bytes
  localparam int NUM_KW = 6;
  localparam logic [47:0] KW_TEXT [NUM_KW] = '{
    48'h7265_7475_726E, 48'h0000_0000_6966, 48'h0000_656C_7365,
    48'h0077_6869_6C65, 48'h0000_0066_6F72, 48'h0000_0069_6E74};
  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd6, 3'd2, 3'd4, 3'd5, 3'd3, 3'd3};

  // result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  code;
    logic [15:0] start;
    logic [15:0] len;
    logic [30:0] value;
    logic        ovf;
    logic        last;
  } res_t;

  typedef struct packed {
    logic       full;
    logic [1:0] push_cnt;
  } qctl_t;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == 8'h5F;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  // one-byte punctuator lookup: bit 5 flags a hit
  function automatic logic [5:0] punct_lookup(input logic [7:0] b);
    logic [5:0] r;
    case (b)
      8'h2B:   r = {1'b1, CODE_PUNCT + 5'd0};
      8'h2D:   r = {1'b1, CODE_PUNCT + 5'd1};
      8'h2A:   r = {1'b1, CODE_PUNCT + 5'd2};
      8'h2F:   r = {1'b1, CODE_PUNCT + 5'd3};
      8'h28:   r = {1'b1, CODE_PUNCT + 5'd4};
      8'h29:   r = {1'b1, CODE_PUNCT + 5'd5};
      8'h3C:   r = {1'b1, CODE_PUNCT + 5'd6};
      8'h3E:   r = {1'b1, CODE_PUNCT + 5'd7};
      8'h3B:   r = {1'b1, CODE_PUNCT + 5'd8};
      8'h3D:   r = {1'b1, CODE_PUNCT + 5'd9};
      8'h7B:   r = {1'b1, CODE_PUNCT + 5'd10};
      8'h7D:   r = {1'b1, CODE_PUNCT + 5'd11};
      8'h2C:   r = {1'b1, CODE_PUNCT + 5'd12};
      8'h26:   r = {1'b1, CODE_PUNCT + 5'd13};
      default: r = 6'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- design/ctok_front.sv -----
// scanner front end: accepts bytes, tracks the pending token, builds results
module ctok_front #(
  parameter int OFFSET_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [7:0]       text_byte_i,
  input  logic             end_of_text_i,
  input  logic             full_i,
  output ctok_pkg::res_t   res0_o,
  output ctok_pkg::res_t   res1_o,
  output logic [1:0]       push_cnt_o
);
  import ctok_pkg::*;

  typedef enum logic [4:0] {
    M_IDLE = 5'b00001,
    M_NUM  = 5'b00010,
    M_WORD = 5'b00100,
    M_OP   = 5'b01000,
    M_ERR  = 5'b10000
  } mode_e;

  mode_e                  mode_q, mode_d;
  logic [15:0]            start_q, start_d;
  logic [15:0]            len_q, len_d;
  logic [30:0]            acc_q, acc_d;
  logic [47:0]            prefix_q, prefix_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic                   sat_q, sat_d;

  logic        accept;
  logic [31:0] pos_ext;
  logic [15:0] pos16;
  logic [7:0]  opc;
  logic [34:0] acc_next;
  logic [5:0]  pl;
  logic [5:0]  opl;
  logic        pv, cv, sv;
  res_t        cres, sres;

  assign accept  = in_valid_i && !full_i;
  assign pos_ext = 32'(pos_q);
  assign pos16   = pos_ext[15:0];
  assign opc     = prefix_q[7:0];
  assign acc_next = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + 35'(text_byte_i - 8'h30);
  assign pl      = punct_lookup(text_byte_i);
  assign opl     = punct_lookup(opc);

  // result for the token that is pending now
  always_comb begin
    cres = '0;
    cres.start = start_q;
    pv = 1'b0;
    case (mode_q)
      M_NUM: begin
        pv = 1'b1;
        cres.kind = KIND_NUM;
        cres.len = len_q;
        cres.value = acc_q;
        cres.ovf = sat_q;
      end
      M_WORD: begin
        pv = 1'b1;
        cres.kind = KIND_ID;
        cres.len = len_q;
        cres.ovf = sat_q;
        for (int k = 0; k < NUM_KW; k++) begin
          if (len_q == 16'(KW_LEN[k]) && prefix_q == KW_TEXT[k]) begin
            cres.kind = KIND_RES;
            cres.code = 5'(k);
            cres.ovf = 1'b0;
          end
        end
      end
      M_OP: begin
        pv = 1'b1;
        cres.len = 16'd1;
        if (opc == 8'h21) begin
          cres.kind = KIND_ERR;
        end else begin
          cres.kind = KIND_RES;
          cres.code = opl[4:0];
        end
      end
      default: pv = 1'b0;
    endcase
  end

  // next state and the result items of this byte
  always_comb begin
    mode_d   = mode_q;
    start_d  = start_q;
    len_d    = len_q;
    acc_d    = acc_q;
    prefix_d = prefix_q;
    pos_d    = pos_q;
    sat_d    = sat_q;
    cv       = pv;
    sv       = 1'b0;
    sres     = '0;
    sres.start = pos16;
    sres.len   = 16'd1;
    res0_o   = '0;
    res1_o   = '0;
    push_cnt_o = 2'd0;
    if (end_of_text_i) begin
      sres.kind = KIND_EOF;
      sres.len  = 16'd0;
      sv = 1'b1;
      mode_d = M_IDLE;
      start_d = '0;
      len_d = '0;
      acc_d = '0;
      prefix_d = '0;
      pos_d = '0;
      sat_d = 1'b0;
    end else begin
      pos_d = pos_q + 1'b1;
      if (mode_q == M_ERR) begin
        cv = 1'b0;
      end else if (mode_q == M_NUM && is_digit(text_byte_i)) begin
        cv = 1'b0;
        if (acc_next > 35'(VAL_MAX)) begin
          acc_d = VAL_MAX;
          sat_d = 1'b1;
        end else begin
          acc_d = acc_next[30:0];
        end
        if (len_q >= LEN_MAX) sat_d = 1'b1;
        else len_d = len_q + 16'd1;
      end else if (mode_q == M_WORD && (is_letter(text_byte_i) || is_digit(text_byte_i))) begin
        cv = 1'b0;
        if (len_q < 16'd6) prefix_d = {prefix_q[39:0], text_byte_i};
        if (len_q >= LEN_MAX) sat_d = 1'b1;
        else len_d = len_q + 16'd1;
      end else if (mode_q == M_OP && text_byte_i == 8'h3D) begin
        cv = 1'b0;
        sv = 1'b1;
        sres.kind  = KIND_RES;
        sres.start = start_q;
        sres.len   = 16'd2;
        case (opc)
          8'h3D:   sres.code = CODE_EQEQ;
          8'h21:   sres.code = CODE_NE;
          8'h3C:   sres.code = CODE_LE;
          default: sres.code = CODE_GE;
        endcase
        mode_d = M_IDLE;
      end else if (mode_q == M_OP && opc == 8'h21) begin
        cv = 1'b0;
        sv = 1'b1;
        sres.kind  = KIND_ERR;
        sres.start = start_q;
        mode_d = M_ERR;
      end else begin
        // close pending token, then start a new one with this byte
        start_d  = pos16;
        len_d    = 16'd1;
        sat_d    = 1'b0;
        acc_d    = '0;
        prefix_d = '0;
        mode_d   = M_IDLE;
        if (is_space(text_byte_i)) begin
          len_d = 16'd0;
        end else if (is_digit(text_byte_i)) begin
          mode_d = M_NUM;
          acc_d = 31'(text_byte_i - 8'h30);
        end else if (is_letter(text_byte_i)) begin
          mode_d = M_WORD;
          prefix_d = 48'(text_byte_i);
        end else if (text_byte_i == 8'h3D || text_byte_i == 8'h21 ||
                     text_byte_i == 8'h3C || text_byte_i == 8'h3E) begin
          mode_d = M_OP;
          prefix_d = 48'(text_byte_i);
        end else if (pl[5]) begin
          sv = 1'b1;
          sres.kind = KIND_RES;
          sres.code = pl[4:0];
        end else begin
          sv = 1'b1;
          sres.kind = KIND_ERR;
          mode_d = M_ERR;
        end
      end
    end
    // pack results, flag the final one
    if (accept) begin
      if (cv && sv) begin
        res0_o = cres;
        res1_o = sres;
        res1_o.last = 1'b1;
        push_cnt_o = 2'd2;
      end else if (cv) begin
        res0_o = cres;
        res0_o.last = 1'b1;
        push_cnt_o = 2'd1;
      end else if (sv) begin
        res0_o = sres;
        res0_o.last = 1'b1;
        push_cnt_o = 2'd1;
      end
    end
  end

  // scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      start_q  <= '0;
      len_q    <= '0;
      acc_q    <= '0;
      prefix_q <= '0;
      pos_q    <= '0;
      sat_q    <= 1'b0;
    end else if (accept) begin
      mode_q   <= mode_d;
      start_q  <= start_d;
      len_q    <= len_d;
      acc_q    <= acc_d;
      prefix_q <= prefix_d;
      pos_q    <= pos_d;
      sat_q    <= sat_d;
    end
  end

  // error mode swallows bytes
  a_err_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_q == M_ERR && !end_of_text_i) |-> push_cnt_o == 2'd0)
    else $error("result pushed while dropping input");
  // the end marker always yields the end token last
  a_eot_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && end_of_text_i) |-> push_cnt_o != 2'd0)
    else $error("end marker without result");
  // end marker returns to idle
  a_eot_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && end_of_text_i) |=> (mode_q == M_IDLE && pos_q == '0))
    else $error("end marker did not reset scanner");
endmodule

// ----- design/ctok_queue.sv -----
// result queue between scanner and output stage, two writes one read per cycle
module ctok_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctok_pkg::res_t   res0_i,
  input  ctok_pkg::res_t   res1_i,
  input  logic [1:0]       push_cnt_i,
  input  logic             pop_i,
  output ctok_pkg::res_t   head_o,
  output logic             nonempty_o,
  output ctok_pkg::qctl_t  ctl_o
);
  import ctok_pkg::*;

  res_t               mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_q, rd_q;
  logic [QCNT_W-1:0]  cnt_q;
  logic [QPTR_W-1:0]  wr_nx;

  assign wr_nx      = wr_q + 1'b1;
  assign head_o     = mem[rd_q];
  assign nonempty_o = cnt_q != '0;
  assign ctl_o.full = cnt_q > QCNT_W'(QDEPTH - 2);
  assign ctl_o.push_cnt = push_cnt_i;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) mem[wr_q] <= res0_i;
    if (push_cnt_i == 2'd2) mem[wr_nx] <= res1_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QPTR_W'(push_cnt_i);
      rd_q  <= rd_q + QPTR_W'(pop_i);
      cnt_q <= cnt_q + QCNT_W'(push_cnt_i) - QCNT_W'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(cnt_q) + 32'(push_cnt_i) - 32'(pop_i)) <= QDEPTH)
    else $error("result queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("pop from empty result queue");
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.full |-> push_cnt_i == 2'd0)
    else $error("push while full");
endmodule

// ----- design/ctok_back.sv -----
// output stage: moves queued results into the output register
module ctok_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctok_pkg::res_t   head_i,
  input  logic             nonempty_i,
  input  logic             out_stall_i,
  output logic             pop_o,
  output logic             out_valid_o,
  output ctok_pkg::res_t   out_o
);
  import ctok_pkg::*;

  logic valid_q;
  res_t data_q;

  assign pop_o       = nonempty_i && (!valid_q || !out_stall_i);
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (!valid_q || !out_stall_i) valid_q <= nonempty_i;
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (pop_o) data_q <= head_i;
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_stall_i) |=> (valid_q && $stable(data_q)))
    else $error("stalled output changed");
  a_pop_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> valid_q)
    else $error("popped item not presented");
  a_no_pop_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_stall_i) |-> !pop_o)
    else $error("pop while output stalled");
endmodule

// ----- design/c_subset_tokenizer.sv -----
// c subset tokenizer top level
// path: the result items of a byte are written into the result queue when the
// byte is accepted, then popped into the output register once it is free
// throughput: one byte per cycle while in_stall_o is low; a byte that gives two
// items pushes both at once into the four-entry result queue
// reset: asynchronous active low, scanner idle at offset 0, queue empty
module c_subset_tokenizer #(
  parameter int OFFSET_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  token_kind_o,
  output logic [4:0]  reserved_code_o,
  output logic [15:0] start_offset_o,
  output logic [15:0] token_length_o,
  output logic [30:0] number_value_o,
  output logic        overflow_o,
  output logic        last_of_run_o
);
  import ctok_pkg::*;

  res_t       res0, res1, head, outr;
  logic [1:0] push_cnt;
  logic       nonempty, pop;
  qctl_t      qctl;

  assign in_stall_o = qctl.full;

  // scanner
  ctok_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .text_byte_i, .end_of_text_i,
    .full_i(qctl.full), .res0_o(res0), .res1_o(res1), .push_cnt_o(push_cnt)
  );

  // result queue
  ctok_queue u_queue (
    .clk_i, .rst_ni, .res0_i(res0), .res1_i(res1), .push_cnt_i(push_cnt),
    .pop_i(pop), .head_o(head), .nonempty_o(nonempty), .ctl_o(qctl)
  );

  // output register
  ctok_back u_back (
    .clk_i, .rst_ni, .head_i(head), .nonempty_i(nonempty), .out_stall_i,
    .pop_o(pop), .out_valid_o, .out_o(outr)
  );

  assign token_kind_o    = outr.kind;
  assign reserved_code_o = outr.code;
  assign start_offset_o  = outr.start;
  assign token_length_o  = outr.len;
  assign number_value_o  = outr.value;
  assign overflow_o      = outr.ovf;
  assign last_of_run_o   = outr.last;
endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for the c subset tokenizer
`timescale 1ns / 100ps

module testbench;
  import ctok_pkg::*;

  localparam int POS_BITS = 16;
  localparam int CYCLE_LIMIT = 400000;

  // scanner modes of the predictor
  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_NUM, SCAN_WORD, SCAN_OP, SCAN_ERR
  } scan_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  text_byte_i = 8'd0;
  logic        end_of_text_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  token_kind_o;
  logic [4:0]  reserved_code_o;
  logic [15:0] start_offset_o;
  logic [15:0] token_length_o;
  logic [30:0] number_value_o;
  logic        overflow_o;
  logic        last_of_run_o;

  c_subset_tokenizer #(.OFFSET_BITS(POS_BITS)) dut (.*);

  always #6 clk_i = ~clk_i;

  // predictor state
  scan_e        lex_mode;
  logic [15:0]  lex_start;
  logic [15:0]  lex_len;
  logic [31:0]  lex_value;
  logic [47:0]  lex_prefix;
  logic [POS_BITS-1:0] lex_pos;
  logic         lex_sat;

  res_t token_queue[$];
  int   errors = 0;
  int   tokens_seen = 0;
  int   items_sent = 0;
  int   cycles = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;

  function automatic res_t make_tok(logic [2:0] k, logic [4:0] c, logic [15:0] s,
                                    logic [15:0] l, logic [30:0] v, logic o);
    res_t r;
    r.kind = k; r.code = c; r.start = s; r.len = l; r.value = v; r.ovf = o;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic logic ch_letter(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic logic ch_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic ch_space(logic [7:0] b);
    return b == " " || (b >= 8'd9 && b <= 8'd13);
  endfunction

  // index into the punctuator list, -1 when none
  function automatic int punct_idx(logic [7:0] b);
    logic [7:0] plist [14] = '{"+", "-", "*", "/", "(", ")", "<", ">", ";", "=",
                               "{", "}", ",", "&"};
    for (int i = 0; i < 14; i++) if (plist[i] == b) return i;
    return -1;
  endfunction

  // keyword match of the collected word, identifier otherwise
  function automatic res_t word_token();
    logic [47:0] kw [6] = '{48'h7265_7475_726E, 48'h6966, 48'h656C_7365,
                            48'h77_6869_6C65, 48'h66_6F72, 48'h69_6E74};
    logic [15:0] kl [6] = '{16'd6, 16'd2, 16'd4, 16'd5, 16'd3, 16'd3};
    for (int k = 0; k < 6; k++)
      if (lex_len == kl[k] && lex_prefix == kw[k])
        return make_tok(KIND_RES, k[4:0], lex_start, lex_len, 31'd0, 1'b0);
    return make_tok(KIND_ID, CODE_NONE, lex_start, lex_len, 31'd0, lex_sat);
  endfunction

  function automatic void close_token(ref res_t outs[$]);
    logic [7:0] c;
    c = lex_prefix[7:0];
    case (lex_mode)
      SCAN_NUM: outs.push_back(make_tok(KIND_NUM, CODE_NONE, lex_start, lex_len,
                                        lex_value[30:0], lex_sat));
      SCAN_WORD: outs.push_back(word_token());
      SCAN_OP:
        if (c == "!") outs.push_back(make_tok(KIND_ERR, CODE_NONE, lex_start, 16'd1,
                                              31'd0, 1'b0));
        else outs.push_back(make_tok(KIND_RES, CODE_PUNCT + 5'(punct_idx(c)), lex_start,
                                     16'd1, 31'd0, 1'b0));
      default: ;
    endcase
  endfunction

  function automatic void grow_len();
    if (lex_len == LEN_MAX) lex_sat = 1'b1;
    else lex_len++;
  endfunction

  function automatic void lex_reset();
    lex_mode = SCAN_IDLE; lex_start = '0; lex_len = '0; lex_value = '0;
    lex_prefix = '0; lex_pos = '0; lex_sat = 1'b0;
  endfunction

  // expected tokens for one input item, appended to the queue
  function automatic void predict_tokens(logic [7:0] b, logic eot);
    res_t outs[$];
    logic [POS_BITS-1:0] pos;
    int p;
    logic [35:0] acc;
    pos = lex_pos;
    if (eot) begin
      close_token(outs);
      outs.push_back(make_tok(KIND_EOF, CODE_NONE, 16'(pos), 16'd0, 31'd0, 1'b0));
      lex_reset();
    end else begin
      lex_pos = pos + 1'b1;
      if (lex_mode == SCAN_ERR) return;
      if (lex_mode == SCAN_NUM && ch_digit(b)) begin
        acc = 36'(lex_value) * 36'd10 + 36'(b - 8'h30);
        if (acc > 36'(VAL_MAX)) begin
          acc = 36'(VAL_MAX); lex_sat = 1'b1;
        end
        lex_value = acc[31:0];
        grow_len();
        return;
      end
      if (lex_mode == SCAN_WORD && (ch_letter(b) || ch_digit(b))) begin
        if (lex_len < 16'd6) lex_prefix = {lex_prefix[39:0], b};
        grow_len();
        return;
      end
      if (lex_mode == SCAN_OP && b == "=") begin
        case (lex_prefix[7:0])
          "=": p = CODE_EQEQ;
          "!": p = CODE_NE;
          "<": p = CODE_LE;
          default: p = CODE_GE;
        endcase
        outs.push_back(make_tok(KIND_RES, p[4:0], lex_start, 16'd2, 31'd0, 1'b0));
        lex_mode = SCAN_IDLE;
      end else if (lex_mode == SCAN_OP && lex_prefix[7:0] == "!") begin
        outs.push_back(make_tok(KIND_ERR, CODE_NONE, lex_start, 16'd1, 31'd0, 1'b0));
        lex_mode = SCAN_ERR;
      end else begin
        close_token(outs);
        lex_mode = SCAN_IDLE;
        // begin a new token at this byte
        lex_start = 16'(pos); lex_len = 16'd1; lex_sat = 1'b0; lex_value = '0;
        lex_prefix = '0;
        p = punct_idx(b);
        if (ch_space(b)) lex_len = 16'd0;
        else if (ch_digit(b)) begin
          lex_mode = SCAN_NUM; lex_value = 32'(b - 8'h30);
        end else if (ch_letter(b)) begin
          lex_mode = SCAN_WORD; lex_prefix = 48'(b);
        end else if (b == "=" || b == "!" || b == "<" || b == ">") begin
          lex_mode = SCAN_OP; lex_prefix = 48'(b);
        end else if (p >= 0) begin
          outs.push_back(make_tok(KIND_RES, CODE_PUNCT + 5'(p), 16'(pos), 16'd1,
                                  31'd0, 1'b0));
        end else begin
          outs.push_back(make_tok(KIND_ERR, CODE_NONE, 16'(pos), 16'd1, 31'd0, 1'b0));
          lex_mode = SCAN_ERR;
        end
      end
    end
    if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
    foreach (outs[i]) token_queue.push_back(outs[i]);
  endfunction

  // send one item, predicting when it is accepted
  task automatic send_item(logic [7:0] b, logic eot);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    text_byte_i <= b;
    end_of_text_i <= eot;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_tokens(b, eot);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic go_quiet();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
  end

  // compare each accepted token with the oldest expectation
  always @(posedge clk_i) begin
    res_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{token_kind_o, reserved_code_o, start_offset_o, token_length_o,
              number_value_o, overflow_o, last_of_run_o};
      tokens_seen++;
      if (token_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected token %p", got);
      end else begin
        want = token_queue.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    send_text("return if else while for int intx iff _a9 Zz");
    send_text("== != <= >= < > = +-*/(){};,& \t\n\v\f\r");
    send_text("0 2147483647 2147483648 99999999999 12ab");
    send_item("<", 1'b0);
    send_item(8'd0, 1'b1);
    send_item("!", 1'b0);
    send_item(8'd0, 1'b1);
    send_text("x!y");
    send_item(8'd0, 1'b1);
    send_text("ab");
    send_item(8'd0, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'd0, 1'b1);
    send_item(8'h80, 1'b0);
    send_item(8'd0, 1'b1);
  endtask

  // mostly program-like text, some noise bytes
  task automatic test_random(int count);
    string words [12] = '{"return", "if", "else", "while", "for", "int", "x1",
                          "_q", "ints", "wh", "forx", "Abc"};
    string ops [8] = '{"==", "!=", "<=", ">=", "!", "<", "=", ">"};
    int n;
    n = items_sent;
    while (items_sent - n < count) begin
      case ($urandom_range(9))
        0, 1, 2: send_text(words[$urandom_range(11)]);
        3: send_item(8'(8'h30 + $urandom_range(9)), 1'b0);
        4: send_text(ops[$urandom_range(7)]);
        5: send_item(" ", 1'b0);
        6: send_item(8'($urandom), 1'b0);
        7: send_item(8'($urandom_range(32, 126)), 1'b0);
        8: send_text("+-*/(){};,&");
        default: if ($urandom_range(3) == 0) send_item(8'($urandom), 1'b1);
                 else send_item(" ", 1'b0);
      endcase
    end
    send_item(8'd0, 1'b1);
  endtask

  task automatic test_long_tokens();
    // long identifier and a number far past the value limit
    for (int i = 0; i < 30; i++) send_item("a", 1'b0);
    send_item(" ", 1'b0);
    for (int i = 0; i < 25; i++) send_item("7", 1'b0);
    send_item(";", 1'b0);
    send_item(8'd0, 1'b1);
  endtask

  task automatic drain();
    int guard;
    go_quiet();
    guard = 0;
    while (token_queue.size() > 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (10) @(posedge clk_i);
  endtask

  initial begin
    lex_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 35; recv_idle_pct = 50;
    test_directed();
    test_random(85);
    send_idle_pct = 50; recv_idle_pct = 35;
    test_random(85);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(85);
    test_long_tokens();
    drain();
    $display("covered %0d items, %0d tokens: keywords, operators, numbers, identifiers,",
             items_sent, tokens_seen);
    $display("error recovery and value saturation; %0d mismatches", errors);
    if (errors == 0 && token_queue.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
